### sv/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// shared types and constants of the q24.8 arithmetic unit
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int DATA_W    = 32;
   localparam int NUM_W     = DATA_W + FRAC_BITS;
   localparam int STAGES    = NUM_W;
   localparam int REM_W     = DATA_W + 2;

   typedef enum logic [3:0] {
      CMD_ADD   = 4'd0,  CMD_SUB  = 4'd1,  CMD_MUL  = 4'd2,  CMD_DIV  = 4'd3,
      CMD_GT    = 4'd4,  CMD_LT   = 4'd5,  CMD_GE   = 4'd6,  CMD_LE   = 4'd7,
      CMD_EQ    = 4'd8,  CMD_NE   = 4'd9,  CMD_MAX  = 4'd10, CMD_MIN  = 4'd11,
      CMD_INC   = 4'd12, CMD_DEC  = 4'd13, CMD_FINT = 4'd14, CMD_TINT = 4'd15
   } cmd_type;

   // one beat travelling down the cell row
   typedef struct packed {
      logic              vld;
      logic              is_div;
      logic              neg;
      logic [DATA_W-1:0] res;
      logic              cmp;
      logic              dz;
      logic [REM_W-1:0]  rem;
      logic [NUM_W-1:0]  num;
      logic [DATA_W-1:0] den;
      logic [NUM_W-1:0]  quo;
   } cell_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              compare_true;
      logic              overflow;
      logic              divide_by_zero;
   } rsp_type;

   function automatic logic [DATA_W-1:0] sat_pack(input logic neg,
                                                 input logic [NUM_W:0] mag,
                                                 output logic ovf);
      logic [NUM_W:0] lim;
      logic [DATA_W-1:0] r;
      begin
         lim = neg ? (NUM_W+1)'(64'h8000_0000) : (NUM_W+1)'(64'h7FFF_FFFF);
         ovf = mag > lim;
         if (ovf) begin
            r = lim[DATA_W-1:0];
         end else if (neg) begin
            r = DATA_W'(-mag);
         end else begin
            r = mag[DATA_W-1:0];
         end
         return r;
      end
   endfunction

endpackage

### sv/fixed_point_alu_q24_8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// q24.8 arithmetic unit with a pipelined restoring divider
// ----------------------------------------------------------------------------
// a request beat carries a command and two raw q24.8 operands; each beat
// gives exactly one response beat with the result and three flags.
// beats are taken on req_tvalid && req_tready and given on
// rsp_tvalid && rsp_tready, in order.
// every command passes one decode and multiply stage, a row of 40 divide
// cells (one quotient bit each) and one rounding stage. throughput is one
// beat per cycle while the receiver does not stall the output.
// the whole row advances together; when the receiver stalls with a beat
// waiting at the output, the row holds and req_tready drops, and a new
// beat is taken while the output is empty or being taken.
// reset clears all valid bits; no beat is pending after it.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8
   import fpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result[31:0], compare_true[32], overflow[33],
                                    // divide_by_zero[34]
);

   cell_type row [STAGES+1];
   logic en;
   rsp_type rsp;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (req_tvalid),
      .command   (req_tdata[3:0]),
      .operand_a (req_tdata[35:4]),
      .operand_b (req_tdata[67:36]),
      .cell_out  (row[0])
   );

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      fpa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .cell_in_d (row[i]),
         .cell_out  (row[i+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cell_in_d (row[STAGES]),
      .out_vld   (rsp_tvalid),
      .rsp_out   (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.divide_by_zero, rsp.overflow, rsp.compare_true, rsp.result};

endmodule

### sv/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front
// decodes a command, runs every operation but divide, the multiplier among them,
// and loads the first cell of the divider row
// ----------------------------------------------------------------------------
module fpa_front
   import fpa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  logic [3:0]               command,
   input  logic signed [DATA_W-1:0] operand_a,
   input  logic signed [DATA_W-1:0] operand_b,
   output cell_type                 cell_out
);

   cell_type cell_ff, cell_in;
   logic signed [2*DATA_W-1:0] prod;
   logic [2*DATA_W-1:0] pmag, mwide;
   logic [NUM_W:0] mround;
   logic ovf_m;
   logic [DATA_W-1:0] mres, amag, bmag;
   logic gt, lt, eq;

   always_comb begin
      gt   = operand_a > operand_b;
      lt   = operand_a < operand_b;
      eq   = operand_a == operand_b;
      prod = operand_a * operand_b;
      pmag = prod[2*DATA_W-1] ? -prod : prod;
      mwide = (pmag + (2*DATA_W)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
      // clamp magnitudes too wide for the saturation check
      mround = (|mwide[2*DATA_W-1:NUM_W+1]) ? '1 : mwide[NUM_W:0];
      mres = sat_pack(prod[2*DATA_W-1], mround, ovf_m);
      amag = operand_a[DATA_W-1] ? DATA_W'(-operand_a) : operand_a;
      bmag = operand_b[DATA_W-1] ? DATA_W'(-operand_b) : operand_b;
      cell_in        = '0;
      cell_in.vld    = in_vld;
      cell_in.num    = {amag, FRAC_BITS'(0)};
      cell_in.den    = bmag;
      cell_in.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
      case (cmd_type'(command))
         CMD_ADD:  cell_in.res = operand_a + operand_b;
         CMD_SUB:  cell_in.res = operand_a - operand_b;
         CMD_MUL:  begin
            cell_in.res = mres;
            cell_in.dz  = 1'b0;
            cell_in.quo = NUM_W'(ovf_m);
         end
         CMD_DIV:  begin
            cell_in.dz     = (operand_b == '0);
            cell_in.is_div = (operand_b != '0);
         end
         CMD_GT:   cell_in.cmp = gt;
         CMD_LT:   cell_in.cmp = lt;
         CMD_GE:   cell_in.cmp = !lt;
         CMD_LE:   cell_in.cmp = !gt;
         CMD_EQ:   cell_in.cmp = eq;
         CMD_NE:   cell_in.cmp = !eq;
         CMD_MAX:  cell_in.res = gt ? operand_a : operand_b;
         CMD_MIN:  cell_in.res = lt ? operand_a : operand_b;
         CMD_INC:  cell_in.res = operand_a + DATA_W'(1);
         CMD_DEC:  cell_in.res = operand_a - DATA_W'(1);
         CMD_FINT: cell_in.res = operand_a << FRAC_BITS;
         CMD_TINT: cell_in.res = operand_a >>> FRAC_BITS;
         default:  cell_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

### sv/fpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cell
// one restoring divide step: brings down a numerator bit, subtracts the
// divisor when it fits and shifts the quotient bit in
// ----------------------------------------------------------------------------
module fpa_cell
   import fpa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cell_type cell_in_d,
   output cell_type cell_out
);

   cell_type cell_ff, cell_in;
   logic [REM_W-1:0] trial;

   always_comb begin
      cell_in = cell_in_d;
      trial   = {cell_in_d.rem[REM_W-2:0], cell_in_d.num[NUM_W-1]};
      if (cell_in_d.is_div) begin
         cell_in.num = cell_in_d.num << 1;
         if (trial >= REM_W'(cell_in_d.den)) begin
            cell_in.rem = trial - REM_W'(cell_in_d.den);
            cell_in.quo = {cell_in_d.quo[NUM_W-2:0], 1'b1};
         end else begin
            cell_in.rem = trial;
            cell_in.quo = {cell_in_d.quo[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

### sv/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back
// rounds and saturates the quotient and registers the result beat
// ----------------------------------------------------------------------------
module fpa_back
   import fpa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  cell_type cell_in_d,
   output logic     out_vld,
   output rsp_type  rsp_out
);

   rsp_type rsp_ff, rsp_in;
   logic vld_ff;
   logic [NUM_W:0] q;
   logic ovf_d;
   logic [DATA_W-1:0] dres;

   always_comb begin
      // round half up: twice the remainder against the divisor
      q = {1'b0, cell_in_d.quo} +
          (NUM_W+1)'({cell_in_d.rem[REM_W-2:0], 1'b0} >= REM_W'(cell_in_d.den));
      dres = sat_pack(cell_in_d.neg, q, ovf_d);
      rsp_in.compare_true   = cell_in_d.cmp;
      rsp_in.divide_by_zero = cell_in_d.dz;
      if (cell_in_d.is_div) begin
         rsp_in.result   = dres;
         rsp_in.overflow = ovf_d;
      end else begin
         rsp_in.result   = cell_in_d.res;
         rsp_in.overflow = cell_in_d.quo[0] & !cell_in_d.dz & (cell_in_d.rem == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= cell_in_d.vld;
         rsp_ff <= rsp_in;
      end
   end

   assign out_vld = vld_ff;
   assign rsp_out = rsp_ff;

endmodule
